/* rtl/tpbd_pkg.sv */
// Shared types and constants for the tile palette bit decoder.
package tpbd_pkg;

   localparam int MaxCells = 2048;

   // result kinds
   localparam logic [1:0] KIND_COUNT = 2'd0;
   localparam logic [1:0] KIND_PAL   = 2'd1;
   localparam logic [1:0] KIND_INDEX = 2'd2;
   localparam logic [1:0] KIND_PIXEL = 2'd3;

   // configuration register indexes
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_FRAMES = 2'd2;
   localparam logic [1:0] REG_PAL    = 2'd3;

   // one result word
   typedef struct packed {
      logic        last;
      logic [1:0]  kind;
      logic [16:0] repeat_cnt;
      logic [15:0] value;
   } result_type;

   // live configuration
   typedef struct packed {
      logic [7:0] grid_width;
      logic [7:0] grid_height;
      logic [7:0] frame_count;
      logic       custom_palette;
   } cfg_type;

endpackage

/* rtl/tile_palette_bit_decoder.sv */
// Top level of the tile palette bit decoder: bit-serial field sequencer.
// A header byte (count, palette, size, pad) is handled in its accept cycle;
// a bit-packed byte is latched, then the shared bit shifter takes one bit per cycle,
// up to 8, stopping early at frame end; a result is valid the cycle after its field.
// No byte is taken while the bit loop runs; input and loop also stall while a result waits.
// Synchronous active-high reset clears control state; the color map is not cleared.
module tile_palette_bit_decoder import tpbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_value[15:0], out_repeat[32:16], out_kind[34:33]
   output logic        rsp_tlast,   // last_of_image
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam logic [3:0] PH_CNT_HI = 4'd0, PH_CNT_LO = 4'd1, PH_PAL = 4'd2,
      PH_SKIP = 4'd3, PH_INDEX = 4'd4, PH_MODE = 4'd5, PH_KIND = 4'd6,
      PH_NCOL = 4'd7, PH_COLOR = 4'd8, PH_CODE = 4'd9, PH_RAW = 4'd10,
      PH_PAD = 4'd11, PH_DONE = 4'd12;

   cfg_type cfg;

   tpbd_cfg u_cfg (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data, .cfg
   );

   logic [3:0]  phase_ff, phase_in;
   logic        busy_ff, busy_in;        // bit loop running on byte_ff
   logic [7:0]  byte_ff, byte_in;
   logic [3:0]  bitpos_ff, bitpos_in;
   logic        parity_ff, parity_in;
   logic [15:0] acc_ff, acc_in;
   logic [4:0]  fill_ff, fill_in;
   logic [15:0] ucount_ff, ucount_in;
   logic [4:0]  ibits_ff, ibits_in;
   logic [3:0]  cmap_ff [8];
   logic        cmap_we;
   logic [2:0]  cmap_wa;
   logic [3:0]  cmap_wd;
   logic [3:0]  ctotal_ff, ctotal_in;
   logic [3:0]  cfill_ff, cfill_in;
   logic [2:0]  cbits_ff, cbits_in;
   logic [16:0] item_ff, item_in;
   logic [15:0] cells_ff, cells_in;
   logic [15:0] grid_ff, grid_in;
   logic [16:0] chunk_ff, chunk_in;
   logic [7:0]  frame_ff, frame_in;
   logic        ov_ff, ov_in;
   result_type  res_ff, res_in;

   // a result blocks the loop until taken
   logic stall;
   assign stall      = ov_ff && !rsp_tready;
   assign req_tready = !busy_ff && !stall;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {5'd0, res_ff.kind, res_ff.repeat_cnt, res_ff.value};
   assign rsp_tlast  = res_ff.last;

   logic acc_req;
   assign acc_req = req_tvalid && req_tready;

   // grid product, saturated
   logic [15:0] prod;
   logic [15:0] grid_sat;
   always_comb begin
      prod     = 16'(cfg.grid_width) * 16'(cfg.grid_height);
      grid_sat = (prod > 16'(MaxCells)) ? 16'(MaxCells) : prod;
   end

   function automatic logic [4:0] bitlen(input logic [15:0] v);
      logic [4:0] l;
      l = 5'd0;
      for (int i = 0; i < 16; i++) if (v[i]) l = 5'(i + 1);
      return l;
   endfunction

   // one field step per cycle, unless a waiting result stalls the loop
   always_comb begin
      logic [15:0] a;
      logic [4:0]  w;
      logic [15:0] v;
      logic        emit, fend;
      logic [2:0]  half, hi, lo;
      logic [15:0] cc;
      phase_in = phase_ff; busy_in = busy_ff; byte_in = byte_ff;
      bitpos_in = bitpos_ff; parity_in = parity_ff; acc_in = acc_ff;
      fill_in = fill_ff; ucount_in = ucount_ff; ibits_in = ibits_ff;
      ctotal_in = ctotal_ff; cfill_in = cfill_ff; cbits_in = cbits_ff;
      item_in = item_ff; cells_in = cells_ff; grid_in = grid_ff;
      chunk_in = chunk_ff; frame_in = frame_ff;
      ov_in = ov_ff && !rsp_tready; res_in = res_ff;
      cmap_we = 1'b0; cmap_wa = cfill_ff[2:0]; cmap_wd = 4'd0;
      a = 16'd0; w = 5'd1; v = 16'd0; emit = 1'b0; fend = 1'b0;
      half = 3'd0; hi = 3'd0; lo = 3'd0; cc = 16'd0;
      if (acc_req) begin
         parity_in = !parity_ff;
         unique case (phase_ff)
            PH_CNT_HI: begin
               if (frame_ff >= cfg.frame_count) phase_in = PH_DONE;
               else begin
                  acc_in = {8'd0, req_tdata};
                  phase_in = PH_CNT_LO;
               end
            end
            PH_CNT_LO: begin
               v = {acc_ff[7:0], req_tdata};
               ucount_in = v; acc_in = 16'd0;
               ov_in = 1'b1; res_in = '{1'b0, KIND_COUNT, 17'd1, v};
               ibits_in = bitlen(v);
               grid_in = grid_sat;
               cc = (v == 16'd0) ? grid_sat : v;
               cells_in = (cc > 16'(MaxCells)) ? 16'(MaxCells) : cc;
               item_in = 17'd0;
               phase_in = cfg.custom_palette ? PH_PAL : PH_SKIP;
            end
            PH_PAL: begin
               if (item_ff[0]) begin
                  ov_in = 1'b1;
                  res_in = '{1'b0, KIND_PAL, 17'd1, {acc_ff[7:0], req_tdata}};
               end else acc_in = {8'd0, req_tdata};
               item_in = item_ff + 17'd1;
               if (item_ff == 17'd31) begin
                  item_in = 17'd0; acc_in = 16'd0; phase_in = PH_SKIP;
               end
            end
            PH_SKIP: begin
               item_in = item_ff + 17'd1;
               if (item_ff >= 17'd1) begin
                  fill_in = 5'd0; acc_in = 16'd0;
                  if (ucount_ff != 16'd0 && grid_ff != 16'd0) begin
                     item_in = {1'b0, grid_ff}; phase_in = PH_INDEX;
                  end else phase_in = PH_MODE;
               end
            end
            PH_PAD: phase_in = PH_CNT_HI;
            // drop every byte after the image
            PH_DONE: ;
            default: begin
               byte_in = req_tdata; busy_in = 1'b1; bitpos_in = 4'd8;
            end
         endcase
      end else if (busy_ff && !stall) begin
         a = {acc_ff[14:0], byte_ff[3'(bitpos_ff - 4'd1)]};
         acc_in = a;
         fill_in = fill_ff + 5'd1;
         bitpos_in = bitpos_ff - 4'd1;
         unique case (phase_ff)
            PH_INDEX: w = ibits_ff;
            PH_NCOL:  w = 5'd3;
            PH_COLOR: w = 5'd4;
            PH_CODE:  w = {2'd0, cbits_ff};
            PH_RAW:   w = 5'd8;
            default:  w = 5'd1;
         endcase
         if (fill_ff + 5'd1 >= w) begin
            v = a; acc_in = 16'd0; fill_in = 5'd0;
            unique case (phase_ff)
               PH_INDEX: begin
                  emit = 1'b1; res_in = '{1'b0, KIND_INDEX, 17'd1, v};
                  item_in = (item_ff != 17'd0) ? item_ff - 17'd1 : item_ff;
                  if (item_ff <= 17'd1) phase_in = PH_MODE;
               end
               PH_MODE: begin
                  if (v[0]) begin
                     chunk_in = {cells_ff, 1'b0} << 4;
                     cells_in = 16'd1;
                  end else chunk_in = 17'd32;
                  if (!v[0] && cells_ff == 16'd0) fend = 1'b1;
                  else phase_in = PH_KIND;
               end
               PH_KIND: begin
                  if (v[0]) phase_in = PH_NCOL;
                  else begin item_in = 17'd32; phase_in = PH_RAW; end
               end
               PH_NCOL: begin
                  ctotal_in = {1'b0, v[2:0]} + 4'd1; cfill_in = 4'd0;
                  phase_in = PH_COLOR;
               end
               PH_COLOR: begin
                  cmap_we = 1'b1; cmap_wd = v[3:0];
                  cfill_in = cfill_ff + 4'd1;
                  if (cfill_ff + 4'd1 >= ctotal_ff) begin
                     if (ctotal_ff > 4'd1) begin
                        cbits_in = (ctotal_ff == 4'd2) ? 3'd2 :
                                   ((ctotal_ff < 4'd5) ? 3'd4 : 3'd6);
                        item_in = chunk_ff;
                        if (chunk_ff == 17'd0) begin
                           cells_in = (cells_ff != 16'd0) ? cells_ff - 16'd1 : cells_ff;
                           if (cells_ff <= 16'd1) fend = 1'b1;
                           else phase_in = PH_KIND;
                        end else phase_in = PH_CODE;
                     end else begin
                        if (chunk_ff != 17'd0) begin
                           emit = 1'b1;
                           res_in = '{1'b0, KIND_PIXEL, chunk_ff,
                                      {8'd0, v[3:0], v[3:0]}};
                        end
                        cells_in = (cells_ff != 16'd0) ? cells_ff - 16'd1 : cells_ff;
                        if (cells_ff <= 16'd1) fend = 1'b1;
                        else phase_in = PH_KIND;
                     end
                  end
               end
               PH_CODE, PH_RAW: begin
                  half = cbits_ff >> 1;
                  hi = 3'((v >> half) & 16'h7);
                  lo = 3'(v & ((16'd1 << half) - 16'd1) & 16'h7);
                  emit = 1'b1;
                  res_in = '{1'b0, KIND_PIXEL, 17'd1,
                     (phase_ff == PH_RAW) ? {8'd0, v[7:0]}
                                          : {8'd0, cmap_ff[hi], cmap_ff[lo]}};
                  item_in = item_ff - 17'd1;
                  if (item_ff == 17'd1) begin
                     cells_in = (cells_ff != 16'd0) ? cells_ff - 16'd1 : cells_ff;
                     if (cells_ff <= 16'd1) fend = 1'b1;
                     else phase_in = PH_KIND;
                  end
               end
               default: ;
            endcase
         end
         if (emit) ov_in = 1'b1;
         if (fend || bitpos_ff == 4'd1) begin
            busy_in = 1'b0;
            if (!fend) begin
               // keep partial field across bytes
            end
         end
         if (fend) begin
            fill_in = 5'd0; acc_in = 16'd0;
            frame_in = frame_ff + 8'd1;
            if (frame_ff + 8'd1 >= cfg.frame_count) begin
               if (emit) res_in.last = 1'b1;
               else if (ov_ff) res_in.last = 1'b1;
               phase_in = PH_DONE;
            end else phase_in = parity_ff ? PH_PAD : PH_CNT_HI;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CNT_HI; busy_ff <= 1'b0; ov_ff <= 1'b0;
         parity_ff <= 1'b0; acc_ff <= 16'd0; fill_ff <= 5'd0;
         ucount_ff <= 16'd0; ibits_ff <= 5'd0; ctotal_ff <= 4'd0;
         cfill_ff <= 4'd0; cbits_ff <= 3'd0; item_ff <= 17'd0;
         cells_ff <= 16'd0; grid_ff <= 16'd0; chunk_ff <= 17'd0;
         frame_ff <= 8'd0; bitpos_ff <= 4'd8;
      end else begin
         phase_ff <= phase_in; busy_ff <= busy_in; ov_ff <= ov_in;
         parity_ff <= parity_in; acc_ff <= acc_in; fill_ff <= fill_in;
         ucount_ff <= ucount_in; ibits_ff <= ibits_in; ctotal_ff <= ctotal_in;
         cfill_ff <= cfill_in; cbits_ff <= cbits_in; item_ff <= item_in;
         cells_ff <= cells_in; grid_ff <= grid_in; chunk_ff <= chunk_in;
         frame_ff <= frame_in; bitpos_ff <= bitpos_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      res_ff  <= res_in;
      if (cmap_we) cmap_ff[cmap_wa] <= cmap_wd;
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_tready) else $error("byte taken while bit loop busy");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped");
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result after image end");
`endif

endmodule

/* rtl/tpbd_cfg.sv */
// Configuration register bank of the tile palette bit decoder.
module tpbd_cfg import tpbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // write one register per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{8'd1, 8'd1, 8'd1, 1'b0};
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_WIDTH:  cfg_ff.grid_width <= csr_data;
            REG_HEIGHT: cfg_ff.grid_height <= csr_data;
            REG_FRAMES: cfg_ff.frame_count <= csr_data;
            REG_PAL:    cfg_ff.custom_palette <= csr_data[0];
            default:    cfg_ff <= cfg_ff;
         endcase
      end
   end

endmodule
